// ===== rtl/priority_slot_task_queue_top_assert.svh =====
// ----------------------------------------------------------------------------
// Priority slot task queue - assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_SLOT_TASK_QUEUE_TOP_ASSERT_SVH
`define PRIORITY_SLOT_TASK_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define PSQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define PSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/psq_pkg.sv =====
// ----------------------------------------------------------------------------
// Priority slot task queue - package
// Shared constants, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package psq_pkg;

	// Default number of priority slots.
	localparam int NUM_SLOTS_DEF = 16;

	// Task ids are six bits wide, so the task table has one entry per id.
	localparam int TASK_W    = 6;
	localparam int NUM_TASKS = 1 << TASK_W;
	localparam int LINK_W    = TASK_W + 1;
	localparam int PRIO_W    = 8;

	// Link value that marks the end of a slot list.
	localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_TASKS);

	// Operation codes on func.
	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	// Controller to datapath commands.
	typedef struct packed {
		logic enq_start;    // accept enqueue: read tail, write head/link, set slot
		logic deq_start;    // accept dequeue: read head of top slot
		logic deq_link_rd;  // read link of dequeued task
		logic enq_commit;   // link old tail to new task, write tail
		logic deq_commit;   // advance head or drop slot
		logic load_out;     // load result beat into output register
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic out_free;     // output register can take a beat this cycle
		logic deq_empty;    // dequeue in flight found the queue empty
	} status_t;

endpackage

// ===== rtl/psq_ram.sv =====
// ----------------------------------------------------------------------------
// Priority slot task queue - generic RAM
// One write port, one read port, registered read data held when not reading.
// ----------------------------------------------------------------------------
module psq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/psq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Priority slot task queue - controller
// Sequences enqueue and dequeue steps and hands results to the output stage.
// ----------------------------------------------------------------------------
module psq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              func,
	input  psq_pkg::status_t  stat,
	output logic              in_stall,
	output psq_pkg::cmd_t     cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ENQ_COMMIT,
		ST_DEQ_LINK,
		ST_DEQ_COMMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (func == psq_pkg::FUNC_DEQ) begin
						cmd.deq_start = 1'b1;
						state_d       = ST_DEQ_LINK;
					end else begin
						cmd.enq_start = 1'b1;
						state_d       = ST_ENQ_COMMIT;
					end
				end
			end
			ST_ENQ_COMMIT: begin
				if (stat.out_free) begin
					cmd.enq_commit = 1'b1;
					cmd.load_out   = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_DEQ_LINK: begin
				if (stat.deq_empty) begin
					// empty queue: report no task, state untouched
					if (stat.out_free) begin
						cmd.load_out = 1'b1;
						state_d      = ST_IDLE;
					end
				end else begin
					cmd.deq_link_rd = 1'b1;
					state_d         = ST_DEQ_COMMIT;
				end
			end
			ST_DEQ_COMMIT: begin
				if (stat.out_free) begin
					cmd.deq_commit = 1'b1;
					cmd.load_out   = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// ===== rtl/psq_datapath.sv =====
// ----------------------------------------------------------------------------
// Priority slot task queue - datapath
// Slot head/tail and task link memories, slot occupancy, top slot tracking,
// and the output register.
// ----------------------------------------------------------------------------
module psq_datapath #(
	parameter int NUM_SLOTS = psq_pkg::NUM_SLOTS_DEF,
	localparam int SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
	localparam int TopW  = $clog2(NUM_SLOTS + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  psq_pkg::cmd_t               cmd,
	output psq_pkg::status_t            stat,
	input  logic [psq_pkg::TASK_W-1:0]  task_id,
	input  logic [psq_pkg::PRIO_W-1:0]  priority_req,
	input  logic                        out_stall,
	output logic                        out_valid,
	output logic                        was_empty,
	output logic                        task_valid,
	output logic [psq_pkg::TASK_W-1:0]  out_task
);

	localparam int TASK_W = psq_pkg::TASK_W;
	localparam int LINK_W = psq_pkg::LINK_W;

	// control state
	logic [NUM_SLOTS-1:0] occ_q;
	logic [TopW-1:0]      top_q;
	logic                 out_valid_q;

	// per-item registers
	logic [TASK_W-1:0] tid_q;
	logic [SlotW-1:0]  slot_q;
	logic              occ_was_q;
	logic              was_empty_q;
	logic              op_deq_q;
	logic              deq_empty_q;

	// output payload
	logic              was_empty_q_o;
	logic              task_valid_q;
	logic [TASK_W-1:0] out_task_q;

	// memory ports
	logic              head_we;
	logic [SlotW-1:0]  head_waddr;
	logic [TASK_W-1:0] head_wdata;
	logic [TASK_W-1:0] head_rdata;
	logic              tail_we;
	logic [TASK_W-1:0] tail_rdata;
	logic              link_we;
	logic [TASK_W-1:0] link_waddr;
	logic [LINK_W-1:0] link_wdata;
	logic [LINK_W-1:0] link_rdata;

	logic [SlotW-1:0]  prio_c;
	logic              empty_now;
	logic              occ_hit;
	logic              nxt_none;
	logic              enc_found;
	logic [SlotW-1:0]  enc_idx;

	// clamp priority to the top slot
	always_comb begin
		if (32'(priority_req) >= 32'(NUM_SLOTS)) begin
			prio_c = SlotW'(NUM_SLOTS - 1);
		end else begin
			prio_c = SlotW'(priority_req);
		end
	end

	assign empty_now = (top_q == TopW'(NUM_SLOTS));
	assign occ_hit   = occ_q[prio_c];
	assign nxt_none  = (link_rdata == psq_pkg::LINK_NONE);

	// highest occupied slot other than the one being dropped
	always_comb begin
		enc_found = 1'b0;
		enc_idx   = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (occ_q[SlotW'(i)] && (SlotW'(i) != slot_q)) begin
				enc_found = 1'b1;
				enc_idx   = SlotW'(i);
			end
		end
	end

	always_comb begin
		head_we    = 1'b0;
		head_waddr = slot_q;
		head_wdata = link_rdata[TASK_W-1:0];
		if (cmd.enq_start) begin
			head_we    = !occ_hit;
			head_waddr = prio_c;
			head_wdata = task_id;
		end else if (cmd.deq_commit) begin
			head_we = !nxt_none;
		end
	end

	always_comb begin
		link_we    = 1'b0;
		link_waddr = task_id;
		link_wdata = psq_pkg::LINK_NONE;
		if (cmd.enq_start) begin
			link_we = 1'b1;
		end else if (cmd.enq_commit) begin
			link_we    = occ_was_q;
			link_waddr = tail_rdata;
			link_wdata = LINK_W'(tid_q);
		end
	end

	assign tail_we = cmd.enq_commit;

	psq_ram #(.WIDTH(TASK_W), .DEPTH(NUM_SLOTS)) u_head (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.re    (cmd.deq_start),
		.raddr (SlotW'(top_q)),
		.rdata (head_rdata)
	);

	psq_ram #(.WIDTH(TASK_W), .DEPTH(NUM_SLOTS)) u_tail (
		.clk   (clk),
		.we    (tail_we),
		.waddr (slot_q),
		.wdata (tid_q),
		.re    (cmd.enq_start),
		.raddr (prio_c),
		.rdata (tail_rdata)
	);

	psq_ram #(.WIDTH(LINK_W), .DEPTH(psq_pkg::NUM_TASKS)) u_link (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (cmd.deq_link_rd),
		.raddr (head_rdata),
		.rdata (link_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			top_q       <= TopW'(NUM_SLOTS);
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.enq_start) begin
				occ_q[prio_c] <= 1'b1;
				if (empty_now || (TopW'(prio_c) > top_q)) begin
					top_q <= TopW'(prio_c);
				end
			end
			if (cmd.deq_commit && nxt_none) begin
				occ_q[slot_q] <= 1'b0;
				top_q         <= enc_found ? TopW'(enc_idx) : TopW'(NUM_SLOTS);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enq_start) begin
			tid_q       <= task_id;
			slot_q      <= prio_c;
			occ_was_q   <= occ_hit;
			was_empty_q <= empty_now;
			op_deq_q    <= 1'b0;
		end
		if (cmd.deq_start) begin
			slot_q      <= SlotW'(top_q);
			deq_empty_q <= empty_now;
			op_deq_q    <= 1'b1;
		end
		if (cmd.load_out) begin
			was_empty_q_o <= !op_deq_q && was_empty_q;
			task_valid_q  <= op_deq_q && !deq_empty_q;
			out_task_q    <= (op_deq_q && !deq_empty_q) ? head_rdata : '0;
		end
	end

	assign stat.out_free  = !out_valid_q || !out_stall;
	assign stat.deq_empty = deq_empty_q;

	assign out_valid  = out_valid_q;
	assign was_empty  = was_empty_q_o;
	assign task_valid = task_valid_q;
	assign out_task   = out_task_q;

endmodule

// ===== rtl/priority_slot_task_queue_top.sv =====
// ----------------------------------------------------------------------------
// Priority slot task queue - top level
// Strict-priority ready queue with one linked-list FIFO per priority slot.
// ----------------------------------------------------------------------------
// An input beat with func = enqueue appends task_id to the FIFO of slot
// priority_req (clamped to the top slot) and returns was_empty, set when the
// whole queue held nothing before it. A beat with func = dequeue removes the
// head of the highest occupied slot and returns it in out_task with
// task_valid set; on an empty queue it returns task_valid = 0, out_task = 0.
// Every input beat yields exactly one output beat, in order. A task id must
// not be enqueued while it is still queued. The block works on one item at a
// time: an enqueue passes through acceptance and commit, a dequeue through
// acceptance, link read and commit (neither on an empty queue). The
// dequeue steps follow two chained registered memory reads, slot head then
// task link, before the slot moves on. A finished result sits in the output
// register, so the next item is accepted while that beat is still stalled;
// an item only waits when its own result finds the output register full.
// No clearing pass is needed after reset: the slot head, tail and link
// memories are only read where an occupancy bit or a link written earlier
// vouches for them.
// ----------------------------------------------------------------------------
`include "priority_slot_task_queue_top_assert.svh"

module priority_slot_task_queue_top #(
	parameter int NUM_SLOTS = psq_pkg::NUM_SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        func,
	input  logic [psq_pkg::TASK_W-1:0]  task_id,
	input  logic [psq_pkg::PRIO_W-1:0]  priority_req,
	// output channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        was_empty,
	output logic                        task_valid,
	output logic [psq_pkg::TASK_W-1:0]  out_task
);

	psq_pkg::cmd_t    cmd;
	psq_pkg::status_t stat;

	// Controller: sequence the memory steps of each item.
	psq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.stat     (stat),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// Datapath: slot lists, occupancy, top slot and output register.
	psq_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.task_id      (task_id),
		.priority_req (priority_req),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.was_empty    (was_empty),
		.task_valid   (task_valid),
		.out_task     (out_task)
	);

	// A result is never loaded over a beat that is still waiting.
	`PSQ_ASSERT_IMPLY(a_load_into_free, clk, arst_n, cmd.load_out, stat.out_free, "result overwrote a stalled beat")

	// An accepted item holds off the next one while it is busy.
	`PSQ_ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && !in_stall, in_stall, "second item accepted while busy")

	// A taken beat without a fresh result is not shown again.
	`PSQ_ASSERT_NEXT(a_no_repeat, clk, arst_n, out_valid && !out_stall && !cmd.load_out, !out_valid, "output beat repeated")

	// Enqueue and dequeue result flags never appear together.
	`PSQ_ASSERT_IMPLY(a_flags_apart, clk, arst_n, out_valid, !(was_empty && task_valid), "was_empty and task_valid both set")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Priority slot task queue - testbench
// Drives enqueue and dequeue beats into the strict-priority ready queue and
// checks every result beat against a typed reply or shadow slot-list model: a
// short scripted opening, then random fill/drain traffic under several idle and
// stall patterns, including a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb;
	import psq_pkg::*;

	localparam int SLOTS       = NUM_SLOTS_DEF;
	localparam int SLOT_W      = $clog2(SLOTS);
	localparam int TOP_W       = $clog2(SLOTS + 1);
	localparam int HOLD_SPAN   = 300;   // cycles of the long output hold-off
	localparam int STUCK_LIMIT = 4000;  // cycles without any accepted beat

	localparam logic [TOP_W-1:0] TOP_EMPTY = TOP_W'(SLOTS);

	// One result beat as the block presents it.
	typedef struct packed {
		logic              was_empty;
		logic              task_valid;
		logic [TASK_W-1:0] out_task;
	} sched_reply_t;

	// One row of the scripted opening; 'typed' marks rows whose reply is
	// written out in the table instead of taken from the shadow model.
	typedef struct packed {
		logic              op;
		logic [TASK_W-1:0] tid;
		logic [PRIO_W-1:0] prio;
		logic              typed;
		sched_reply_t      reply;
	} script_row_t;

	logic              clk;
	logic              arst_n       = 1'b0;
	logic              in_valid     = 1'b0;
	logic              in_stall;
	logic              func         = FUNC_ENQ;
	logic [TASK_W-1:0] task_id      = '0;
	logic [PRIO_W-1:0] priority_req = '0;
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic              was_empty;
	logic              task_valid;
	logic [TASK_W-1:0] out_task;

	// Shadow copy of the ready queue.
	logic [TASK_W-1:0] sh_head [SLOTS]     = '{default: '0};
	logic [TASK_W-1:0] sh_tail [SLOTS]     = '{default: '0};
	logic              sh_occ  [SLOTS]     = '{default: 1'b0};
	logic [LINK_W-1:0] sh_link [NUM_TASKS] = '{default: '0};
	logic [TOP_W-1:0]  sh_top              = TOP_EMPTY;
	logic [NUM_TASKS-1:0] queued           = '0;  // ids believed to be waiting

	sched_reply_t sched_replies [$];  // replies owed by the block, oldest first

	int idle_pct   = 0;  // sender: chance in 100 of an idle cycle
	int stall_pct  = 0;  // receiver: chance in 100 of a stall cycle
	bit hold_ask   = 1'b0;
	int errors     = 0;
	int quiet_cyc  = 0;

	script_row_t script [24] = '{
		// dequeue on an empty queue returns no task
		'{FUNC_DEQ, 6'd0,  8'd0,   1'b1, '{1'b0, 1'b0, 6'd0}},
		'{FUNC_ENQ, 6'd0,  8'd0,   1'b1, '{1'b1, 1'b0, 6'd0}},
		// slot 0 empties: the queue goes empty
		'{FUNC_DEQ, 6'd0,  8'd0,   1'b1, '{1'b0, 1'b1, 6'd0}},
		'{FUNC_DEQ, 6'd0,  8'd0,   1'b1, '{1'b0, 1'b0, 6'd0}},
		// priorities above the top slot clamp to it
		'{FUNC_ENQ, 6'd63, 8'd255, 1'b1, '{1'b1, 1'b0, 6'd0}},
		'{FUNC_ENQ, 6'd21, 8'd15,  1'b1, '{1'b0, 1'b0, 6'd0}},
		'{FUNC_ENQ, 6'd42, 8'd16,  1'b1, '{1'b0, 1'b0, 6'd0}},
		'{FUNC_ENQ, 6'd5,  8'd7,   1'b0, '0},
		'{FUNC_ENQ, 6'd6,  8'd7,   1'b0, '0},
		'{FUNC_ENQ, 6'd7,  8'd0,   1'b0, '0},
		'{FUNC_ENQ, 6'd8,  8'd128, 1'b0, '0},
		// dequeue ignores task_id and priority_req, even all ones
		'{FUNC_DEQ, 6'd63, 8'd255, 1'b1, '{1'b0, 1'b1, 6'd63}},
		'{FUNC_DEQ, 6'd0,  8'd0,   1'b1, '{1'b0, 1'b1, 6'd21}},
		'{FUNC_DEQ, 6'd0,  8'd0,   1'b1, '{1'b0, 1'b1, 6'd42}},
		'{FUNC_DEQ, 6'd0,  8'd0,   1'b1, '{1'b0, 1'b1, 6'd8}},
		// top slot drops down through slot 7 to slot 0
		'{FUNC_DEQ, 6'd0,  8'd0,   1'b0, '0},
		'{FUNC_DEQ, 6'd0,  8'd0,   1'b0, '0},
		'{FUNC_DEQ, 6'd0,  8'd0,   1'b0, '0},
		'{FUNC_DEQ, 6'd0,  8'd0,   1'b1, '{1'b0, 1'b0, 6'd0}},
		// same task queued twice, in two slots
		'{FUNC_ENQ, 6'd9,  8'd3,   1'b1, '{1'b1, 1'b0, 6'd0}},
		'{FUNC_ENQ, 6'd9,  8'd10,  1'b1, '{1'b0, 1'b0, 6'd0}},
		'{FUNC_DEQ, 6'd0,  8'd0,   1'b0, '0},
		'{FUNC_DEQ, 6'd0,  8'd0,   1'b0, '0},
		'{FUNC_DEQ, 6'd0,  8'd0,   1'b1, '{1'b0, 1'b0, 6'd0}}
	};

	priority_slot_task_queue_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.task_id      (task_id),
		.priority_req (priority_req),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.was_empty    (was_empty),
		.task_valid   (task_valid),
		.out_task     (out_task)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Apply one operation to the shadow queue and return the reply it owes.
	function automatic sched_reply_t sched_apply(logic op, logic [TASK_W-1:0] tid,
			logic [PRIO_W-1:0] prio);
		sched_reply_t      r;
		logic [SLOT_W-1:0] s;
		logic [TASK_W-1:0] t;
		logic [LINK_W-1:0] nxt;
		logic              empty;
		r = '0;
		if (op == FUNC_ENQ) begin
			empty = (sh_top == TOP_EMPTY);
			s = (prio >= SLOTS) ? SLOT_W'(SLOTS - 1) : SLOT_W'(prio);
			if (empty || TOP_W'(s) > sh_top)
				sh_top = TOP_W'(s);
			// terminate the new task's link first, then hook it behind the tail
			sh_link[tid] = LINK_NONE;
			if (sh_occ[s]) begin
				sh_link[sh_tail[s]] = LINK_W'(tid);
			end else begin
				sh_head[s] = tid;
				sh_occ[s]  = 1'b1;
			end
			sh_tail[s]  = tid;
			queued[tid] = 1'b1;
			r.was_empty = empty;
		end else if (sh_top != TOP_EMPTY && sh_occ[SLOT_W'(sh_top)]) begin
			s   = SLOT_W'(sh_top);
			t   = sh_head[s];
			nxt = sh_link[t];
			if (nxt == LINK_NONE) begin
				// slot drained: drop the mark to the next occupied slot below
				sh_occ[s] = 1'b0;
				sh_top    = TOP_EMPTY;
				for (int k = int'(s) - 1; k >= 0 && sh_top == TOP_EMPTY; k--)
					if (sh_occ[SLOT_W'(k)])
						sh_top = TOP_W'(k);
			end else begin
				sh_head[s] = nxt[TASK_W-1:0];
			end
			queued[t]    = 1'b0;
			r.task_valid = 1'b1;
			r.out_task   = t;
		end
		return r;
	endfunction

	// Offer one input beat; hold it until accepted, then log the owed reply.
	// Returns in the time step of acceptance with in_valid still high.
	task automatic offer_item(logic op, logic [TASK_W-1:0] tid, logic [PRIO_W-1:0] prio,
			logic typed, sched_reply_t typed_reply);
		sched_reply_t r;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		func         <= op;
		task_id      <= tid;
		priority_req <= prio;
		do
			@(posedge clk);
		while (in_stall);
		r = sched_apply(op, tid, prio);
		sched_replies.push_back(typed ? typed_reply : r);
	endtask

	// Random traffic: alternate fill-heavy and drain-heavy stretches so the
	// queue both climbs through many slots and runs dry now and then.
	task automatic random_run(int n);
		logic              op;
		logic [TASK_W-1:0] tid;
		logic [PRIO_W-1:0] prio;
		int                enq_pct;
		for (int i = 0; i < n; i++) begin
			enq_pct = ((i / 40) % 2 == 0) ? 72 : 32;
			tid  = TASK_W'($urandom_range(NUM_TASKS - 1));
			prio = ($urandom_range(3) == 0) ? PRIO_W'($urandom_range(255))
			                                : PRIO_W'($urandom_range(SLOTS - 1));
			if (!(&queued) && $urandom_range(99) < enq_pct) begin
				op = FUNC_ENQ;
				// never queue an id that is still waiting
				while (queued[tid])
					tid = tid + 1'b1;
			end else begin
				op = FUNC_DEQ;
			end
			offer_item(op, tid, prio, 1'b0, '0);
		end
	endtask

	// Output side: check each accepted beat, then pick the stall for the
	// next cycle; a hold-off request takes over the stall for the long hold-off.
	initial begin
		sched_reply_t want;
		int           hold_cnt;
		hold_cnt = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (sched_replies.size() == 0) begin
					$error("result beat with no reply pending: task_valid %0d out_task %0d",
						task_valid, out_task);
					errors++;
				end else begin
					want = sched_replies.pop_front();
					if (was_empty !== want.was_empty) begin
						$error("was_empty: expected %0d, got %0d", want.was_empty, was_empty);
						errors++;
					end
					if (task_valid !== want.task_valid) begin
						$error("task_valid: expected %0d, got %0d", want.task_valid, task_valid);
						errors++;
					end
					if (out_task !== want.out_task) begin
						$error("out_task: expected %0d, got %0d", want.out_task, out_task);
						errors++;
					end
				end
			end
			if (hold_ask) begin
				hold_ask = 1'b0;
				hold_cnt = HOLD_SPAN;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Watchdog: end the run if no beat moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cyc = 0;
			else
				quiet_cyc++;
			if (quiet_cyc >= STUCK_LIMIT) begin
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		// hold reset from time zero, then release it on an edge
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// scripted opening, no idling
		foreach (script[i])
			offer_item(script[i].op, script[i].tid, script[i].prio,
				script[i].typed, script[i].reply);

		// random traffic under each idle pattern
		random_run(200);
		idle_pct  = 77;
		random_run(200);
		idle_pct  = 0;
		stall_pct = 77;
		random_run(200);
		idle_pct  = 7;
		stall_pct = 7;
		random_run(200);

		// long output hold-off while input keeps coming: block fills and stalls
		idle_pct  = 0;
		stall_pct = 0;
		hold_ask  = 1'b1;
		random_run(120);

		// closing stretch with no idling
		random_run(110);
		in_valid <= 1'b0;

		// drain every owed reply, then let the block sit idle
		while (sched_replies.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
